// ----- design/cpack_lse_pkg.sv -----
`timescale 1ns / 1ps

package cpack_lse_pkg;

    localparam int WORD_W = 32;
    localparam int PAT_W  = 3;
    localparam int LEN_W  = 6;
    localparam int SIZE_W = 12;
    localparam int NUM_LENS = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [SIZE_W-1:0] SIZE_MAX = 12'd4095;

    // Pattern codes, also the index of the matching length register
    localparam logic [PAT_W-1:0] PAT_ZZZZ = 3'd0;
    localparam logic [PAT_W-1:0] PAT_XXXX = 3'd1;
    localparam logic [PAT_W-1:0] PAT_MMMM = 3'd2;
    localparam logic [PAT_W-1:0] PAT_MMXX = 3'd3;
    localparam logic [PAT_W-1:0] PAT_ZZZX = 3'd4;
    localparam logic [PAT_W-1:0] PAT_MMMX = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_ZZZZ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_XXXX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_MMMM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_MMXX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_ZZZX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_MMMX = 3'd5;

    // Search result handed from older cell to newer cell
    typedef struct packed {
        logic             hit;
        logic [PAT_W-1:0] pat;
    } probe_t;

endpackage

// ----- design/cpack_line_size_estimator_unit.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   s_tdata = word_bytes, s_tlast = last_word
// m_        out  m_tvalid/m_tready   m_tdata = pattern, word_bits, line_bits;
//                                     m_tlast = line_done
// cfg_      in   cfg_wr_en           cfg_index, cfg_wdata (no read-back)
//
// One word per cycle unless stalled: the word is compared against every
// dictionary cell in the cycle it is accepted and its result lands in the
// output register on the next edge. The priority walk along the cell chain
// and the size adder set the path length. s_tready drops only while a
// result waits on a low m_tready. Synchronous active-low reset zeroes the
// dictionary, running size and output valid and restores the length defaults.

module cpack_line_size_estimator_unit
    import cpack_lse_pkg::*;
#(
    parameter int DICT_ENTRIES = 16
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // write port for the length registers
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_wdata,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] word_bytes
    input  logic                 s_tlast,   // last_word
    // per-word results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // [2:0] pattern, [8:3] word_bits,
                                            // [20:9] line_bits, [23:21] zero
    output logic                 m_tlast    // line_done
);

    logic [LEN_W-1:0]  len_reg [NUM_LENS];
    logic [SIZE_W-1:0] running_reg;
    logic [SIZE_W-1:0] running_next;
    logic              m_tvalid_reg;
    logic [23:0]       m_tdata_reg;
    logic              m_tlast_reg;

    logic              accept;
    logic              zero_prefix;
    logic              shift_en;
    logic [PAT_W-1:0]  pat;
    logic [LEN_W-1:0]  bits;
    logic [SIZE_W:0]   sum;
    logic [SIZE_W-1:0] total;

    probe_t            probe [DICT_ENTRIES+1];
    logic [WORD_W-1:0] entry [DICT_ENTRIES];

    assign s_tready = aresetn & (~m_tvalid_reg | m_tready);
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Cell 0 holds the oldest entry; the search walks from there to the newest
    assign probe[0] = '{hit: 1'b0, pat: PAT_XXXX};

    genvar gi;
    generate
        for (gi = 0; gi < DICT_ENTRIES; gi++) begin : g_cell
            logic [WORD_W-1:0] feed;
            if (gi == DICT_ENTRIES - 1) begin : g_newest
                assign feed = s_tdata;
            end else begin : g_inner
                assign feed = entry[gi+1];
            end
            cpack_lse_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift_en  (shift_en),
                .entry_in  (feed),
                .word      (s_tdata),
                .probe_in  (probe[gi]),
                .probe_out (probe[gi+1]),
                .entry_out (entry[gi])
            );
        end
    endgenerate

    assign zero_prefix = (s_tdata[23:0] == 24'd0);

    always_comb begin
        if (zero_prefix) begin
            pat = (s_tdata[31:24] == 8'd0) ? PAT_ZZZZ : PAT_ZZZX;
        end else begin
            pat = probe[DICT_ENTRIES].pat;
        end
    end

    // Drop the oldest entry and append the word only on a miss whose low 24 bits are nonzero
    assign shift_en = accept & ~zero_prefix & ~probe[DICT_ENTRIES].hit;

    always_comb begin
        case (pat)
            PAT_ZZZZ: bits = len_reg[CFG_LEN_ZZZZ];
            PAT_XXXX: bits = len_reg[CFG_LEN_XXXX];
            PAT_MMMM: bits = len_reg[CFG_LEN_MMMM];
            PAT_MMXX: bits = len_reg[CFG_LEN_MMXX];
            PAT_ZZZX: bits = len_reg[CFG_LEN_ZZZX];
            PAT_MMMX: bits = len_reg[CFG_LEN_MMMX];
            default:  bits = '0;
        endcase
    end

    // Saturate the running size at its top value
    assign sum          = {1'b0, running_reg} + {{(SIZE_W+1-LEN_W){1'b0}}, bits};
    assign total        = sum[SIZE_W] ? SIZE_MAX : sum[SIZE_W-1:0];
    assign running_next = s_tlast ? '0 : total;

    // Length registers; ignore indexes past the last register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg[CFG_LEN_ZZZZ] <= 6'd2;
            len_reg[CFG_LEN_XXXX] <= 6'd34;
            len_reg[CFG_LEN_MMMM] <= 6'd6;
            len_reg[CFG_LEN_MMXX] <= 6'd24;
            len_reg[CFG_LEN_ZZZX] <= 6'd12;
            len_reg[CFG_LEN_MMMX] <= 6'd16;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LEN_ZZZZ: len_reg[CFG_LEN_ZZZZ] <= cfg_wdata;
                CFG_LEN_XXXX: len_reg[CFG_LEN_XXXX] <= cfg_wdata;
                CFG_LEN_MMMM: len_reg[CFG_LEN_MMMM] <= cfg_wdata;
                CFG_LEN_MMXX: len_reg[CFG_LEN_MMXX] <= cfg_wdata;
                CFG_LEN_ZZZX: len_reg[CFG_LEN_ZZZX] <= cfg_wdata;
                CFG_LEN_MMMX: len_reg[CFG_LEN_MMMX] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Running size; restart after the last word of a line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= '0;
        end else if (accept) begin
            running_reg <= running_next;
        end
    end

    // Output register: load on accept, clear valid once the request is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {3'b000, total, bits, pat};
            m_tlast_reg <= s_tlast;
        end
    end

endmodule

// ----- design/cpack_lse_cell.sv -----
`timescale 1ns / 1ps

module cpack_lse_cell
    import cpack_lse_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              shift_en,
    input  logic [WORD_W-1:0] entry_in,
    input  logic [WORD_W-1:0] word,
    input  probe_t            probe_in,
    output probe_t            probe_out,
    output logic [WORD_W-1:0] entry_out
);

    logic [WORD_W-1:0] entry_reg;
    logic              match;
    logic [PAT_W-1:0]  local_pat;

    assign entry_out = entry_reg;
    assign match     = (word[15:0] == entry_reg[15:0]);

    always_comb begin
        if (word[23:16] != entry_reg[23:16]) begin
            local_pat = PAT_MMXX;
        end else if (word[31:24] == entry_reg[31:24]) begin
            local_pat = PAT_MMMM;
        end else begin
            local_pat = PAT_MMMX;
        end
    end

    // Keep the first hit from the older side; otherwise claim it here
    always_comb begin
        if (probe_in.hit) begin
            probe_out = probe_in;
        end else begin
            probe_out.hit = match;
            probe_out.pat = match ? local_pat : probe_in.pat;
        end
    end

    // Advance toward the oldest end when a literal word is inserted
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else if (shift_en) begin
            entry_reg <= entry_in;
        end
    end

endmodule

// ----- design/cpack_lse_checker.sv -----
`timescale 1ns / 1ps

module cpack_lse_checker
    import cpack_lse_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

    // Every accepted word yields a result next cycle carrying its line end mark
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (m_tvalid && (m_tlast == $past(s_tlast))))
        else $error("missing result or wrong line end");

    // An all-zero word is always zzzz
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tdata == 32'd0)) |=> (m_tdata[2:0] == PAT_ZZZZ))
        else $error("zero word not classified zzzz");

    // Pattern code in range and line size covers this word's length
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[2:0] != 3'd6) && (m_tdata[2:0] != 3'd7)
                      && ({6'd0, m_tdata[8:3]} <= m_tdata[20:9])))
        else $error("bad result fields");

endmodule

bind cpack_line_size_estimator_unit cpack_lse_checker u_cpack_lse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- tb/sv/line_size_check.sv -----
`timescale 1ns / 1ps

module line_size_check
    import cpack_lse_pkg::*;
#(
    parameter int DICT_ENTRIES = 16
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [31:0]          s_tdata,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [23:0]          m_tdata,
    input  logic                 m_tlast,
    output int                   fail_count,
    output int                   pending
);

    localparam int BITS_LO = PAT_W;
    localparam int LINE_LO = PAT_W + LEN_W;
    localparam int PAD_LO  = PAT_W + LEN_W + SIZE_W;

    typedef struct packed {
        logic [PAT_W-1:0]  pattern;
        logic [LEN_W-1:0]  word_bits;
        logic [SIZE_W-1:0] line_bits;
        logic              line_done;
    } word_result_t;

    logic [WORD_W-1:0] dict [DICT_ENTRIES];
    int                oldest;
    logic [SIZE_W-1:0] run_bits;
    logic [LEN_W-1:0]  lens [NUM_LENS];
    word_result_t      word_results_q [$];
    int                mismatches = 0;
    int                queued = 0;

    assign fail_count = mismatches;
    assign pending    = queued;

    task automatic reset_model();
        int i;
        for (i = 0; i < DICT_ENTRIES; i++) dict[i] = '0;
        oldest   = 0;
        run_bits = '0;
        lens[PAT_ZZZZ] = 6'd2;
        lens[PAT_XXXX] = 6'd34;
        lens[PAT_MMMM] = 6'd6;
        lens[PAT_MMXX] = 6'd24;
        lens[PAT_ZZZX] = 6'd12;
        lens[PAT_MMMX] = 6'd16;
        word_results_q.delete();
    endtask

    // Classify one word against the dictionary (oldest entry first), charge its
    // length and queue the result it must produce.
    task automatic classify_and_size(input logic [WORD_W-1:0] w, input logic last);
        logic [PAT_W-1:0]  pat;
        logic              hit;
        logic [WORD_W-1:0] e;
        logic [SIZE_W:0]   sum;
        word_result_t      r;
        int                j;
        hit = 1'b0;
        pat = PAT_XXXX;
        if (w[23:0] == 24'd0) begin
            pat = (w == '0) ? PAT_ZZZZ : PAT_ZZZX;
        end else begin
            for (j = 0; j < DICT_ENTRIES; j++) begin
                e = dict[(oldest + j) % DICT_ENTRIES];
                if (!hit && w[15:0] == e[15:0]) begin
                    hit = 1'b1;
                    if (w[23:16] != e[23:16]) pat = PAT_MMXX;
                    else pat = (w == e) ? PAT_MMMM : PAT_MMMX;
                end
            end
            if (!hit) begin
                dict[oldest] = w;
                oldest = (oldest + 1) % DICT_ENTRIES;
                pat = PAT_XXXX;
            end
        end
        sum = {1'b0, run_bits} + {{(SIZE_W + 1 - LEN_W){1'b0}}, lens[pat]};
        if (sum > {1'b0, SIZE_MAX}) sum = {1'b0, SIZE_MAX};
        r.pattern   = pat;
        r.word_bits = lens[pat];
        r.line_bits = sum[SIZE_W-1:0];
        r.line_done = last;
        word_results_q.insert(word_results_q.size(), r);
        run_bits = last ? '0 : sum[SIZE_W-1:0];
    endtask

    always @(posedge aclk) begin : watch
        word_result_t want;
        if (!aresetn) begin
            reset_model();
        end else begin
            if (cfg_wr_en && cfg_index < NUM_LENS) lens[cfg_index] = cfg_wdata;
            // results drain before the word taken at this edge is queued
            if (m_tvalid && m_tready) begin
                if (word_results_q.size() == 0) begin
                    $error("result with no word pending: m_tdata=%h m_tlast=%b",
                           m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    want = word_results_q[0];
                    word_results_q.delete(0);
                    if (m_tdata[PAT_W-1:0] !== want.pattern) begin
                        $error("pattern: expected %0d, actual %0d",
                               want.pattern, m_tdata[PAT_W-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[LINE_LO-1:BITS_LO] !== want.word_bits) begin
                        $error("word_bits: expected %0d, actual %0d",
                               want.word_bits, m_tdata[LINE_LO-1:BITS_LO]);
                        mismatches++;
                    end
                    if (m_tdata[PAD_LO-1:LINE_LO] !== want.line_bits) begin
                        $error("line_bits: expected %0d, actual %0d",
                               want.line_bits, m_tdata[PAD_LO-1:LINE_LO]);
                        mismatches++;
                    end
                    if (m_tdata[23:PAD_LO] !== '0) begin
                        $error("tdata pad: expected 0, actual %0d", m_tdata[23:PAD_LO]);
                        mismatches++;
                    end
                    if (m_tlast !== want.line_done) begin
                        $error("line_done: expected %0d, actual %0d",
                               want.line_done, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) classify_and_size(s_tdata, s_tlast);
        end
        queued = word_results_q.size();
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import cpack_lse_pkg::*;

    // unused register indexes: writes there must leave every length alone
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_AFTER   = 150;   // results seen before the long hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int RECENT_DEPTH = 16;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;     // [31:0] word_bytes
    logic                 s_tlast = 1'b0;   // last_word
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;          // [2:0] pattern, [8:3] word_bits,
                                            // [20:9] line_bits, [23:21] zero
    logic                 m_tlast;          // line_done

    int check_fails;
    int check_pending;

    int cycle_count = 0;
    int words_sent = 0;
    int lines_sent = 0;
    int settings_used = 0;
    int results_taken = 0;
    bit tx_steady = 1'b0;

    logic [31:0] recent_words [$];

    cpack_line_size_estimator_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    line_size_check line_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (check_fails),
        .pending    (check_pending)
    );

    always #5 aclk = ~aclk;

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly zero gaps, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver: alternate ready runs with stalls of random length. Once
    // HOLD_AFTER results have been taken, hold off for HOLD_CYCLES so the
    // output register fills and s_tready has to drop while words keep coming.
    int  run_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) results_taken++;
        if (!hold_done && results_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (run_left > 0) begin
            run_left--;
            m_tready <= 1'b1;
        end else begin
            run_left   = $urandom_range(1, 20);
            stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() + 1 : 0;
            m_tready <= 1'b1;
        end
    end

    // Write one register; caller owns the edge that follows.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Load all six lengths plus junk at the spare indexes, then release.
    task automatic set_lengths(input logic [LEN_W-1:0] zzzz, input logic [LEN_W-1:0] xxxx,
                               input logic [LEN_W-1:0] mmmm, input logic [LEN_W-1:0] mmxx,
                               input logic [LEN_W-1:0] zzzx, input logic [LEN_W-1:0] mmmx);
        write_reg(CFG_SPARE_LO, LEN_W'($urandom));
        write_reg(CFG_LEN_ZZZZ, zzzz);
        write_reg(CFG_LEN_XXXX, xxxx);
        write_reg(CFG_LEN_MMMM, mmmm);
        write_reg(CFG_LEN_MMXX, mmxx);
        write_reg(CFG_LEN_ZZZX, zzzx);
        write_reg(CFG_LEN_MMMX, mmmx);
        write_reg(CFG_SPARE_HI, LEN_W'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        settings_used++;
    endtask

    // Drop valid and wait until every queued result has come out. Sample on
    // the falling edge so the checker's count for this cycle is settled.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (check_pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input logic [31:0] w, input logic last);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        if (last) lines_sent++;
        recent_words.insert(recent_words.size(), w);
        if (recent_words.size() > RECENT_DEPTH) recent_words.delete(0);
    endtask

    // Random word, biased toward the recently sent ones so the dictionary
    // hits every match pattern, not just literals.
    function automatic logic [31:0] make_word();
        int          r;
        logic [31:0] rnd;
        logic [31:0] pick;
        r    = $urandom_range(0, 99);
        rnd  = $urandom;
        pick = (recent_words.size() > 0) ?
               recent_words[$urandom_range(0, recent_words.size() - 1)] : rnd;
        if (r < 8)  return 32'd0;
        if (r < 16) return {rnd[7:0], 24'd0};
        if (r < 20) return {rnd[15:0], 16'd0};
        if (r < 45) return rnd;
        if (r < 65) return pick;
        if (r < 78) return {rnd[7:0], pick[23:0]};
        if (r < 90) return {rnd[15:0], pick[15:0]};
        return {pick[31:16], rnd[15:0]};
    endfunction

    // One line of n random words; some lines go out back to back.
    task automatic send_line(input int n);
        int i;
        tx_steady = ($urandom_range(0, 4) == 0);
        for (i = 1; i <= n; i++) send_word(make_word(), i == n);
        tx_steady = 1'b0;
    endtask

    // Random lines until the phase has taken about `count` more words.
    task automatic random_lines(input int count);
        int stop_at;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) send_line($urandom_range(30, 80));
            else send_line($urandom_range(1, 8));
        end
    endtask

    initial begin : stimulus
        int k;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Phase 1: default lengths, written back explicitly.
        set_lengths(6'd2, 6'd34, 6'd6, 6'd24, 6'd12, 6'd16);

        // Dictionary still all zero: zero words and low-half-zero words hit it.
        send_word(32'h0000_0000, 1'b0);          // zzzz
        send_word(32'h0005_0000, 1'b0);          // mmxx against a zero entry
        send_word(32'hA500_0000, 1'b0);          // zzzx
        send_word(32'h1234_5678, 1'b0);          // literal, enters dictionary
        send_word(32'h1234_5678, 1'b0);          // mmmm
        send_word(32'hFF34_5678, 1'b0);          // mmmx
        send_word(32'h12AB_5678, 1'b0);          // mmxx
        send_word(32'hFFFF_FFFF, 1'b1);          // literal, ends the line
        send_word(32'hFFFF_FFFF, 1'b1);          // one-word line, mmmm
        send_word(32'h0000_0001, 1'b0);          // literal
        send_word(32'h0100_0000, 1'b0);          // zzzx, smallest nonzero top byte
        // Push enough literals through to wrap the FIFO and evict the oldest.
        for (k = 0; k < 14; k++) send_word(32'h00C0_1000 + k, k == 13);
        send_word(32'h1234_5678, 1'b1);          // evicted, so a literal again

        random_lines(130);
        wait_drained();

        // Phase 2: every length at maximum; a long first line saturates.
        set_lengths(6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63);
        send_line(70);
        random_lines(60);
        wait_drained();

        // Phase 3: every length zero.
        set_lengths(6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0);
        random_lines(90);
        wait_drained();

        // Phases 4 and 5: random lengths.
        repeat (2) begin
            set_lengths(LEN_W'($urandom), LEN_W'($urandom), LEN_W'($urandom),
                        LEN_W'($urandom), LEN_W'($urandom), LEN_W'($urandom));
            random_lines(80);
            wait_drained();
        end

        // Let the pipeline settle, then judge on a quiet edge.
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        $display("Sent %0d words in %0d lines under %0d length settings (defaults, all max,",
                 words_sent, lines_sent, settings_used);
        $display("all zero, random); receiver held off %0d cycles once to back up the input.",
                 HOLD_CYCLES);
        if (check_fails == 0 && check_pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
